// ===== hw/rtl/bqsa_pkg.sv =====
// Package for the bounded queue server admission block.
// Holds the controller states, the command and status structs and shared constants.
// Used by every module of the block; depends on nothing.
package bqsa_pkg;

    localparam int DEFAULT_QUEUE_SLOTS = 64;
    localparam int TIME_W = 48;
    localparam int IN_W = 32;
    localparam int CAP_W = 6;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_DECIDE
    } bqsa_state_t;

    typedef struct packed {
        logic latch;
        logic pop;
        logic commit;
    } bqsa_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic head_done;
        logic out_free;
    } bqsa_status_t;

endpackage

// ===== hw/rtl/bqsa_ctrl.sv =====
// Controller state machine of the bounded queue server admission block.
// Sequences one request: head retirement, admission decision and result load.
// Depends on bqsa_pkg.
module bqsa_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  bqsa_pkg::bqsa_status_t status,
    output bqsa_pkg::bqsa_cmd_t   cmd
);

    bqsa_pkg::bqsa_state_t state_reg;
    bqsa_pkg::bqsa_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bqsa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            bqsa_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    state_next = bqsa_pkg::ST_READ;
                end
            end
            bqsa_pkg::ST_READ:
            begin
                state_next = bqsa_pkg::ST_CHECK;
            end
            bqsa_pkg::ST_CHECK:
            begin
                if (!status.count_zero && status.head_done)
                begin
                    cmd.pop = 1'b1;
                    state_next = bqsa_pkg::ST_READ;
                end
                else
                begin
                    state_next = bqsa_pkg::ST_DECIDE;
                end
            end
            bqsa_pkg::ST_DECIDE:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = bqsa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bqsa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/bqsa_datapath.sv =====
// Datapath of the bounded queue server admission block.
// Holds the finish time memory, queue pointers, finish time adder and output register.
// Depends on bqsa_pkg; driven by commands from bqsa_ctrl.
module bqsa_datapath #(
    parameter int QUEUE_SLOTS = bqsa_pkg::DEFAULT_QUEUE_SLOTS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bqsa_pkg::bqsa_cmd_t            cmd,
    output bqsa_pkg::bqsa_status_t         status,
    input  logic [bqsa_pkg::CAP_W-1:0]     queue_capacity,
    input  logic [bqsa_pkg::IN_W-1:0]      arrival_time,
    input  logic [bqsa_pkg::IN_W-1:0]      duration,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           accepted,
    output logic [bqsa_pkg::TIME_W-1:0]    finish_time
);

    localparam int IDX_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int CNT_W = $clog2(QUEUE_SLOTS + 1);
    localparam int CMP_W = ((CNT_W > bqsa_pkg::CAP_W) ? CNT_W : bqsa_pkg::CAP_W) + 1;
    localparam int TIME_W = bqsa_pkg::TIME_W;
    localparam int IN_W = bqsa_pkg::IN_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_SLOTS - 1);
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(QUEUE_SLOTS);
    localparam logic [IDX_W:0] SLOTS_EXT = (IDX_W + 1)'(QUEUE_SLOTS);

    logic [TIME_W-1:0] mem [QUEUE_SLOTS];
    logic [TIME_W-1:0] rd_data_reg;

    logic [IDX_W-1:0]  head_reg;
    logic [IDX_W-1:0]  head_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [TIME_W-1:0] last_reg;
    logic [TIME_W-1:0] last_next;
    logic [IN_W-1:0]   arrival_reg;
    logic [IN_W-1:0]   duration_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              accepted_reg;
    logic [TIME_W-1:0] finish_reg;

    logic [TIME_W-1:0] arrival_ext;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] fin;
    logic              full;
    logic              admit;
    logic [IDX_W:0]    tail_sum;
    logic [IDX_W-1:0]  tail_idx;

    assign arrival_ext = {{(TIME_W - IN_W){1'b0}}, arrival_reg};
    assign start_time = (last_reg > arrival_ext) ? last_reg : arrival_ext;
    assign sum = {1'b0, start_time} + {{(TIME_W + 1 - IN_W){1'b0}}, duration_reg};
    assign fin = sum[TIME_W] ? bqsa_pkg::TIME_MAX : sum[TIME_W-1:0];

    assign full = (CMP_W'(count_reg) > CMP_W'(queue_capacity)) || (count_reg == SLOTS_CNT);
    assign admit = cmd.commit && !full;

    assign tail_sum = {1'b0, head_reg} + (IDX_W + 1)'(count_reg);
    assign tail_idx = (tail_sum >= SLOTS_EXT) ? IDX_W'(tail_sum - SLOTS_EXT)
                                              : tail_sum[IDX_W-1:0];

    assign status.count_zero = (count_reg == '0);
    assign status.head_done = (rd_data_reg <= arrival_ext);
    assign status.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[head_reg];
        if (admit)
        begin
            mem[tail_idx] <= fin;
        end
    end

    always_comb
    begin
        head_next = head_reg;
        count_next = count_reg;
        last_next = last_reg;
        if (cmd.pop)
        begin
            head_next = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        else if (admit)
        begin
            count_next = count_reg + 1'b1;
            last_next = fin;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            count_reg <= '0;
            last_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            count_reg <= count_next;
            last_reg <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            arrival_reg <= arrival_time;
            duration_reg <= duration;
        end
        if (cmd.commit)
        begin
            accepted_reg <= !full;
            finish_reg <= full ? '0 : fin;
        end
    end

    assign out_valid = out_valid_reg;
    assign accepted = accepted_reg;
    assign finish_time = finish_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= SLOTS_CNT)
        else $error("job count exceeds the slot count");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (count_reg != '0))
        else $error("head retired from an empty queue");

    a_commit_output: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("result not presented after commit");

    a_admit_count: assert property (@(posedge clk) disable iff (!rst_n)
        admit |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("admitted job not counted");

    a_commit_not_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> status.out_free)
        else $error("result overwritten while a transfer is pending");

endmodule

// ===== hw/rtl/bounded_queue_server_admission.sv =====
// Top level of the bounded queue server admission block: a single server with a
// FIFO waiting line and tail drop. Holds the configuration register and joins the
// controller (bqsa_ctrl) to the datapath (bqsa_datapath); depends on bqsa_pkg.
//
// Usage: a request transfer (arrival_time, duration) is taken on the input channel
// when in_valid is high and in_stall is low. Each request yields exactly one result
// transfer (accepted, finish_time) on the output channel, taken when out_valid is
// high and out_stall is low. queue_capacity must be written through the APB port at
// address 0 while the block is idle; the block itself does not enforce this.
// A request passes ST_IDLE, ST_READ, ST_CHECK and ST_DECIDE, and repeats ST_READ
// and ST_CHECK for every queued job it retires: the finish time memory has a single
// read port and is walked one queue head at a time. The result is then held in the
// output register, and the next request is taken while it waits. If the receiver
// stalls, the held result stays and the block stops before loading the next result.
// Reset clears the queue, the last finish time and the capacity register; the finish
// time memory itself is not cleared and needs no clearing pass.
module bounded_queue_server_admission #(
    parameter int QUEUE_SLOTS = bqsa_pkg::DEFAULT_QUEUE_SLOTS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [bqsa_pkg::IN_W-1:0]    arrival_time,
    input  logic [bqsa_pkg::IN_W-1:0]    duration,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         accepted,
    output logic [bqsa_pkg::TIME_W-1:0]  finish_time
);

    logic [bqsa_pkg::CAP_W-1:0] cap_reg;
    logic [bqsa_pkg::CAP_W-1:0] cap_next;
    logic                       cap_sel;

    bqsa_pkg::bqsa_cmd_t    cmd;
    bqsa_pkg::bqsa_status_t status;

    assign pready = 1'b1;
    assign cap_sel = (paddr[2] == 1'b0);

    always_comb
    begin
        cap_next = cap_reg;
        if (psel && penable && pwrite && pready && cap_sel)
        begin
            cap_next = pwdata[bqsa_pkg::CAP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= '0;
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    assign prdata = cap_sel ? {{(32 - bqsa_pkg::CAP_W){1'b0}}, cap_reg} : 32'd0;

    bqsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    bqsa_datapath #(
        .QUEUE_SLOTS (QUEUE_SLOTS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .queue_capacity (cap_reg),
        .arrival_time   (arrival_time),
        .duration       (duration),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .accepted       (accepted),
        .finish_time    (finish_time)
    );

endmodule
